### design/tds_pkg.sv
`default_nettype none
package tds_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_RHS  = 4;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CNT_W    = ROW_W + 1;
    localparam int RHS_W    = $clog2(MAX_RHS) + 1;
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int QUO_W    = DATA_W + FRAC_W;
    localparam int WIDE_W   = QUO_W + 1;
    localparam int ADDR_W   = 4;

    typedef enum logic [1:0] {
        REG_FIRST_ROW = 2'd0,
        REG_ROW_COUNT = 2'd1,
        REG_RHS_COUNT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic             ld_we;
        logic [ROW_W-1:0] ld_row;
        logic [ROW_W-1:0] row;
        logic             fwd;
        logic             mul;
        logic             prd;
        logic             sub;
        logic             first;
        logic             store;
        logic             bk_store;
    } ctl_t;

    function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[WIDE_W-1:DATA_W-1] == {(WIDE_W-DATA_W+1){v[DATA_W-1]}}) begin
            r = v[DATA_W-1:0];
        end else if (v[WIDE_W-1]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] qsub(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] d;
        logic signed [DATA_W-1:0] r;
        d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (d[DATA_W] == d[DATA_W-1]) begin
            r = d[DATA_W-1:0];
        end else if (d[DATA_W]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

    // Shifts the full product down by the fraction width, truncating toward zero.
    function automatic logic signed [DATA_W-1:0] qmul_post(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] adj;
        logic signed [PROD_W-1:0] sh;
        adj = p + (p[PROD_W-1] ? PROD_W'((1 << FRAC_W) - 1) : PROD_W'(0));
        sh  = adj >>> FRAC_W;
        return sat_wide(sh[WIDE_W-1:0]);
    endfunction

endpackage
`default_nettype wire

### design/tds_div.sv
`default_nettype none
module tds_div (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic signed [tds_pkg::DATA_W-1:0]     num,
    input  wire logic signed [tds_pkg::DATA_W-1:0]     den,
    output logic                                       done,
    output logic signed [tds_pkg::DATA_W-1:0]          quot
);
    import tds_pkg::*;

    localparam int STEP_W = $clog2(QUO_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [DATA_W-1:0] dm_reg;
    logic              neg_reg;
    logic              zero_reg;

    logic [DATA_W-1:0] num_abs;
    logic [DATA_W-1:0] den_abs;
    logic [DATA_W:0]   trial;
    logic              fits;
    logic signed [WIDE_W-1:0] signed_q;

    assign num_abs  = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
    assign den_abs  = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
    assign trial    = {rem_reg, quo_reg[QUO_W-1]};
    assign fits     = trial >= {1'b0, dm_reg};
    assign signed_q = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(QUO_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            rem_reg  <= '0;
            quo_reg  <= {num_abs, {FRAC_W{1'b0}}};
            dm_reg   <= den_abs;
            neg_reg  <= num[DATA_W-1] ^ den[DATA_W-1];
            zero_reg <= (den == '0);
        end else if (busy_reg) begin
            rem_reg <= fits ? DATA_W'(trial - {1'b0, dm_reg}) : trial[DATA_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = zero_reg ? '0 : sat_wide(signed_q);

endmodule
`default_nettype wire

### design/tds_pivot.sv
`default_nettype none
module tds_pivot (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire tds_pkg::ctl_t                      ctl,
    input  wire logic signed [tds_pkg::DATA_W-1:0]  upper,
    input  wire logic signed [tds_pkg::DATA_W-1:0]  diag,
    input  wire logic signed [tds_pkg::DATA_W-1:0]  lower,
    output logic signed [tds_pkg::DATA_W-1:0]       b_val,
    output logic signed [tds_pkg::DATA_W-1:0]       a_val,
    output logic signed [tds_pkg::DATA_W-1:0]       den,
    output logic                                    div_done
);
    import tds_pkg::*;

    logic signed [DATA_W-1:0] upper_mem [MAX_ROWS];
    logic signed [DATA_W-1:0] diag_mem  [MAX_ROWS];
    logic signed [DATA_W-1:0] lower_mem [MAX_ROWS];
    logic signed [DATA_W-1:0] a_mem     [MAX_ROWS];

    logic signed [DATA_W-1:0] up_rd_reg;
    logic signed [DATA_W-1:0] dg_rd_reg;
    logic signed [DATA_W-1:0] lo_rd_reg;
    logic signed [DATA_W-1:0] a_rd_reg;
    logic signed [DATA_W-1:0] a_prev_reg;
    logic signed [PROD_W-1:0] p_reg;
    logic signed [DATA_W-1:0] q_reg;
    logic signed [DATA_W-1:0] div_q;

    always_ff @(posedge clk) begin
        if (ctl.ld_we) begin
            upper_mem[ctl.ld_row] <= upper;
            diag_mem[ctl.ld_row]  <= diag;
            lower_mem[ctl.ld_row] <= lower;
        end
        up_rd_reg <= upper_mem[ctl.row];
        dg_rd_reg <= diag_mem[ctl.row];
        lo_rd_reg <= lower_mem[ctl.row];
    end

    always_ff @(posedge clk) begin
        if (ctl.store) begin
            a_mem[ctl.row] <= div_q;
        end
        a_rd_reg <= a_mem[ctl.row];
    end

    always_ff @(posedge clk) begin
        if (ctl.mul && ctl.fwd) begin
            p_reg <= a_prev_reg * lo_rd_reg;
        end
        if (ctl.prd) begin
            q_reg <= qmul_post(p_reg);
        end
        if (ctl.store) begin
            a_prev_reg <= div_q;
        end
    end

    assign den = ctl.first ? dg_rd_reg : qsub(dg_rd_reg, q_reg);

    tds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.sub),
        .num   (up_rd_reg),
        .den   (den),
        .done  (div_done),
        .quot  (div_q)
    );

    assign b_val = lo_rd_reg;
    assign a_val = a_rd_reg;

endmodule
`default_nettype wire

### design/tds_lane.sv
`default_nettype none
module tds_lane (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire tds_pkg::ctl_t                      ctl,
    input  wire logic signed [tds_pkg::DATA_W-1:0]  rhs,
    input  wire logic signed [tds_pkg::DATA_W-1:0]  b_val,
    input  wire logic signed [tds_pkg::DATA_W-1:0]  a_val,
    input  wire logic signed [tds_pkg::DATA_W-1:0]  den,
    output logic signed [tds_pkg::DATA_W-1:0]       sol
);
    import tds_pkg::*;

    logic signed [DATA_W-1:0] rhs_mem [MAX_ROWS];
    logic signed [DATA_W-1:0] c_mem   [MAX_ROWS];

    logic signed [DATA_W-1:0] rhs_rd_reg;
    logic signed [DATA_W-1:0] c_rd_reg;
    logic signed [DATA_W-1:0] c_prev_reg;
    logic signed [PROD_W-1:0] p_reg;
    logic signed [DATA_W-1:0] q_reg;
    logic signed [DATA_W-1:0] mul_op;
    logic signed [DATA_W-1:0] num;
    logic signed [DATA_W-1:0] back_val;
    logic signed [DATA_W-1:0] div_q;
    logic                     div_done;

    assign mul_op   = ctl.fwd ? b_val : a_val;
    assign num      = ctl.first ? rhs_rd_reg : qsub(rhs_rd_reg, q_reg);
    assign back_val = qsub(c_rd_reg, q_reg);

    always_ff @(posedge clk) begin
        if (ctl.ld_we) begin
            rhs_mem[ctl.ld_row] <= rhs;
        end
        rhs_rd_reg <= rhs_mem[ctl.row];
    end

    always_ff @(posedge clk) begin
        if (ctl.store) begin
            c_mem[ctl.row] <= div_q;
        end else if (ctl.bk_store) begin
            c_mem[ctl.row] <= back_val;
        end
        c_rd_reg <= c_mem[ctl.row];
    end

    always_ff @(posedge clk) begin
        if (ctl.mul) begin
            p_reg <= c_prev_reg * mul_op;
        end
        if (ctl.prd) begin
            q_reg <= qmul_post(p_reg);
        end
        if (ctl.store) begin
            c_prev_reg <= div_q;
        end else if (ctl.bk_store) begin
            c_prev_reg <= back_val;
        end
    end

    tds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.sub),
        .num   (num),
        .den   (den),
        .done  (div_done),
        .quot  (div_q)
    );

    assign sol = (div_done && !ctl.store) ? '0 : c_rd_reg;

endmodule
`default_nettype wire

### design/tridiagonal_system_solver.sv
`default_nettype none
// Solves one tridiagonal system in signed Q16.16 by the Thomas algorithm. Rows are loaded one
// transfer per cycle; the transfer with final_row set starts the solve, during which no input is
// taken. Forward elimination waits, for each active row, on the 48-step divider that the pivot
// unit and each right-hand-side lane run in lockstep. Back substitution steps each row through
// read, multiply, product and subtract states; each solution row is held until accepted. A zero
// pivot ends elimination early; every solution row then carries pivot_error and zero solutions.
module tridiagonal_system_solver (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [tds_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [tds_pkg::DATA_W-1:0]         pwdata,
    output logic [tds_pkg::DATA_W-1:0]              prdata,
    output logic                                    pready,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [tds_pkg::ROW_W-1:0]          row,
    input  wire logic signed [tds_pkg::DATA_W-1:0]  upper,
    input  wire logic signed [tds_pkg::DATA_W-1:0]  diag,
    input  wire logic signed [tds_pkg::DATA_W-1:0]  lower,
    input  wire logic signed [tds_pkg::DATA_W-1:0]  rhs_0,
    input  wire logic signed [tds_pkg::DATA_W-1:0]  rhs_1,
    input  wire logic signed [tds_pkg::DATA_W-1:0]  rhs_2,
    input  wire logic signed [tds_pkg::DATA_W-1:0]  rhs_3,
    input  wire logic                               final_row,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [tds_pkg::ROW_W-1:0]               out_row,
    output logic signed [tds_pkg::DATA_W-1:0]       solution_0,
    output logic signed [tds_pkg::DATA_W-1:0]       solution_1,
    output logic signed [tds_pkg::DATA_W-1:0]       solution_2,
    output logic signed [tds_pkg::DATA_W-1:0]       solution_3,
    output logic                                    last_out,
    output logic                                    pivot_error
);
    import tds_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_F_RD  = 12'b0000_0000_0010,
        S_F_MUL = 12'b0000_0000_0100,
        S_F_PRD = 12'b0000_0000_1000,
        S_F_SUB = 12'b0000_0001_0000,
        S_F_DIV = 12'b0000_0010_0000,
        S_B_RD  = 12'b0000_0100_0000,
        S_B_MUL = 12'b0000_1000_0000,
        S_B_PRD = 12'b0001_0000_0000,
        S_B_SUB = 12'b0010_0000_0000,
        S_O_RD  = 12'b0100_0000_0000,
        S_O_SHW = 12'b1000_0000_0000
    } state_t;

    state_t            state_reg;
    logic [ROW_W-1:0]  first_row_reg;
    logic [CNT_W-1:0]  row_count_reg;
    logic [RHS_W-1:0]  rhs_count_reg;
    logic [ROW_W-1:0]  j_reg;
    logic [ROW_W-1:0]  j0_reg;
    logic [ROW_W-1:0]  last_reg;
    logic [RHS_W-1:0]  nr_reg;
    logic              err_reg;

    logic [CNT_W-1:0]  n_eff;
    logic [ROW_W-1:0]  last_eff;
    logic [ROW_W-1:0]  j0_eff;
    logic [RHS_W-1:0]  nr_eff;
    logic              cfg_we;
    logic              in_acc;
    logic              out_acc;
    logic              back;
    ctl_t              ctl;

    logic signed [DATA_W-1:0] lane_rhs [MAX_RHS];
    logic signed [DATA_W-1:0] lane_sol [MAX_RHS];
    logic signed [DATA_W-1:0] sol_out  [MAX_RHS];
    logic signed [DATA_W-1:0] b_val;
    logic signed [DATA_W-1:0] a_val;
    logic signed [DATA_W-1:0] den;
    logic                     div_done;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign in_ready = (state_reg == S_IDLE);
    assign in_acc  = in_valid && in_ready;
    assign out_valid = (state_reg == S_O_SHW);
    assign out_acc = out_valid && out_ready;

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_FIRST_ROW: prdata = DATA_W'(first_row_reg);
            REG_ROW_COUNT: prdata = DATA_W'(row_count_reg);
            REG_RHS_COUNT: prdata = DATA_W'(rhs_count_reg);
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        if (row_count_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (row_count_reg > CNT_W'(MAX_ROWS)) begin
            n_eff = CNT_W'(MAX_ROWS);
        end else begin
            n_eff = row_count_reg;
        end
        last_eff = ROW_W'(n_eff - 1'b1);
        j0_eff   = (first_row_reg > last_eff) ? last_eff : first_row_reg;
        if (rhs_count_reg == '0) begin
            nr_eff = RHS_W'(1);
        end else if (rhs_count_reg > RHS_W'(MAX_RHS)) begin
            nr_eff = RHS_W'(MAX_RHS);
        end else begin
            nr_eff = rhs_count_reg;
        end
    end

    assign back = (state_reg == S_B_RD) || (state_reg == S_B_MUL) ||
                  (state_reg == S_B_PRD) || (state_reg == S_B_SUB);

    always_comb begin
        ctl.ld_we    = in_acc;
        ctl.ld_row   = row;
        ctl.row      = back ? ROW_W'(j_reg - 1'b1) : j_reg;
        ctl.fwd      = !back;
        ctl.mul      = (state_reg == S_F_MUL) || (state_reg == S_B_MUL);
        ctl.prd      = (state_reg == S_F_PRD) || (state_reg == S_B_PRD);
        ctl.sub      = (state_reg == S_F_SUB);
        ctl.first    = (j_reg == j0_reg);
        ctl.store    = (state_reg == S_F_DIV) && div_done;
        ctl.bk_store = (state_reg == S_B_SUB);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            first_row_reg <= '0;
            row_count_reg <= CNT_W'(MAX_ROWS);
            rhs_count_reg <= RHS_W'(1);
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_FIRST_ROW: first_row_reg <= pwdata[ROW_W-1:0];
                REG_ROW_COUNT: row_count_reg <= pwdata[CNT_W-1:0];
                REG_RHS_COUNT: rhs_count_reg <= pwdata[RHS_W-1:0];
                default:       first_row_reg <= first_row_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            j_reg     <= '0;
            j0_reg    <= '0;
            last_reg  <= '0;
            nr_reg    <= RHS_W'(1);
            err_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (in_acc && final_row) begin
                        j0_reg    <= j0_eff;
                        j_reg     <= j0_eff;
                        last_reg  <= last_eff;
                        nr_reg    <= nr_eff;
                        err_reg   <= 1'b0;
                        state_reg <= S_F_RD;
                    end
                end
                S_F_RD:  state_reg <= S_F_MUL;
                S_F_MUL: state_reg <= S_F_PRD;
                S_F_PRD: state_reg <= S_F_SUB;
                S_F_SUB: begin
                    if (den == '0) begin
                        err_reg <= 1'b1;
                    end
                    state_reg <= S_F_DIV;
                end
                S_F_DIV: begin
                    if (div_done) begin
                        if (err_reg || (j_reg == last_reg && j_reg == j0_reg)) begin
                            j_reg     <= '0;
                            state_reg <= S_O_RD;
                        end else if (j_reg == last_reg) begin
                            state_reg <= S_B_RD;
                        end else begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_F_RD;
                        end
                    end
                end
                S_B_RD:  state_reg <= S_B_MUL;
                S_B_MUL: state_reg <= S_B_PRD;
                S_B_PRD: state_reg <= S_B_SUB;
                S_B_SUB: begin
                    if (ROW_W'(j_reg - 1'b1) == j0_reg) begin
                        j_reg     <= '0;
                        state_reg <= S_O_RD;
                    end else begin
                        j_reg     <= j_reg - 1'b1;
                        state_reg <= S_B_RD;
                    end
                end
                S_O_RD:  state_reg <= S_O_SHW;
                S_O_SHW: begin
                    if (out_acc) begin
                        if (j_reg == last_reg) begin
                            state_reg <= S_IDLE;
                        end else begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_O_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign lane_rhs[0] = rhs_0;
    assign lane_rhs[1] = rhs_1;
    assign lane_rhs[2] = rhs_2;
    assign lane_rhs[3] = rhs_3;

    tds_pivot u_pivot (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .upper    (upper),
        .diag     (diag),
        .lower    (lower),
        .b_val    (b_val),
        .a_val    (a_val),
        .den      (den),
        .div_done (div_done)
    );

    for (genvar k = 0; k < MAX_RHS; k++) begin : g_lane
        tds_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .rhs   (lane_rhs[k]),
            .b_val (b_val),
            .a_val (a_val),
            .den   (den),
            .sol   (lane_sol[k])
        );

        assign sol_out[k] = (err_reg || (RHS_W'(k) >= nr_reg) || (j_reg < j0_reg)) ?
                            '0 : lane_sol[k];
    end

    assign out_row     = j_reg;
    assign solution_0  = sol_out[0];
    assign solution_1  = sol_out[1];
    assign solution_2  = sol_out[2];
    assign solution_3  = sol_out[3];
    assign last_out    = (j_reg == last_reg);
    assign pivot_error = err_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while a result is pending");

    a_solve_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && final_row) |=> (state_reg == S_F_RD))
        else $error("final row did not start the solve");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_out) |=> (state_reg == S_IDLE))
        else $error("block did not return to idle after the last result");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_row <= last_reg))
        else $error("result row past the last row");

endmodule
`default_nettype wire
